### design/rlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared types and constants for the run-length FIFO with weighted take.
// ----------------------------------------------------------------------------
package rlf_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 32;
  localparam int TOTAL_W = 64;
  localparam int ENTRY_W = VALUE_W + COUNT_W;

  // command field codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  // status field codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ACC,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic acc;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic start_loop;
    logic more;
  } dp_status_t;

endpackage : rlf_pkg
`default_nettype wire

### design/run_length_fifo_weighted_take.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_fifo_weighted_take
// FIFO of runs (value, count) with a weighted take from the front.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word carries in_cmd, in_run_value
//   and in_amount. A push appends a run at the tail; a push into a full ring
//   is dropped and reported with out_status = 1. A take removes up to
//   in_amount elements from the front and reports sum(value) and the count.
//   Output channel (out_valid / out_stall): exactly one word per input word,
//   in order. A push or an empty/zero take reports zeros in total/taken.
//   Sequence: a push or a take that consumes nothing goes from IDLE to FIN;
//   a take steps CALC then ACC once for each run it touches: CALC multiplies
//   the head run's value by the part taken and pops or writes back the head,
//   ACC adds the product to the total while the RAM reads the next head run.
//   FIN loads the result register; a new word is taken only in IDLE.
//   The result register holds one finished word; a new word is accepted
//   while it waits, and the block holds its next result until the receiver
//   lifts out_stall. Reset (rst_n low, synchronous) empties the ring and
//   drops any pending result; the run RAM itself is not cleared.
// ----------------------------------------------------------------------------
module run_length_fifo_weighted_take #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [rlf_pkg::VALUE_W-1:0]  in_run_value,
  input  wire logic [rlf_pkg::COUNT_W-1:0]  in_amount,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [rlf_pkg::TOTAL_W-1:0]  out_total,
  output logic      [rlf_pkg::COUNT_W-1:0]  out_taken,
  output logic                              out_status
);
  import rlf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencer: IDLE -> (CALC -> ACC)* -> FIN
  rlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring storage, pointers, multiply-accumulate, result register
  rlf_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_cmd      (in_cmd),
    .in_run_value(in_run_value),
    .in_amount   (in_amount),
    .out_total   (out_total),
    .out_taken   (out_taken),
    .out_status  (out_status),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule : run_length_fifo_weighted_take
`default_nettype wire

### design/rlf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : rlf_ram
`default_nettype wire

### design/rlf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlf_ctrl
// Sequencer: accepts a word, steps the take loop, hands off to the output
// register.
// ----------------------------------------------------------------------------
module rlf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire rlf_pkg::dp_status_t sts,
  output rlf_pkg::ctrl_cmd_t      cmd
);
  import rlf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.start_loop ? ST_CALC : ST_FIN;
        end
      end
      ST_CALC: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = sts.more ? ST_CALC : ST_FIN;
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_CALC: cmd.calc = 1'b1;
      ST_ACC:  cmd.acc  = 1'b1;
      ST_FIN:  cmd.load_out = slot_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule : rlf_ctrl
`default_nettype wire

### design/rlf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlf_dp
// Datapath: run ring in RAM, head/tail/occupancy, take accumulator and
// output register.
// ----------------------------------------------------------------------------
module rlf_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_cmd,
  input  wire logic [rlf_pkg::VALUE_W-1:0]  in_run_value,
  input  wire logic [rlf_pkg::COUNT_W-1:0]  in_amount,
  output logic      [rlf_pkg::TOTAL_W-1:0]  out_total,
  output logic      [rlf_pkg::COUNT_W-1:0]  out_taken,
  output logic                              out_status,
  input  wire rlf_pkg::ctrl_cmd_t           cmd,
  output rlf_pkg::dp_status_t               sts
);
  import rlf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  logic [PW-1:0]      head_r, head_nxt;
  logic [PW-1:0]      tail_r, tail_nxt;
  logic [OW-1:0]      occ_r, occ_nxt;
  logic [COUNT_W-1:0] need_r, need_nxt;
  logic [COUNT_W-1:0] taken_r, taken_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] prod_r, prod_nxt;
  logic               status_r, status_nxt;
  logic [TOTAL_W-1:0] out_total_r;
  logic [COUNT_W-1:0] out_taken_r;
  logic               out_status_r;

  logic               full;
  logic               push_ok;
  logic [ENTRY_W-1:0] rd_data;
  logic [VALUE_W-1:0] rd_value;
  logic [COUNT_W-1:0] rd_count;
  logic [COUNT_W-1:0] sub;
  logic [COUNT_W-1:0] remain;
  logic               we;
  logic [PW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;

  assign full     = (occ_r == OW'(QUEUE_DEPTH));
  assign push_ok  = cmd.accept && (in_cmd == CMD_PUSH) && !full;
  assign rd_value = rd_data[ENTRY_W-1 -: VALUE_W];
  assign rd_count = rd_data[COUNT_W-1:0];
  assign sub      = (need_r < rd_count) ? need_r : rd_count;
  assign remain   = rd_count - sub;

  // head entry is always on the read port
  rlf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(head_r),
    .rdata(rd_data)
  );

  // push at tail, or write back the leftover of a partly taken head run
  always_comb begin
    we    = 1'b0;
    waddr = tail_r;
    wdata = {in_run_value, in_amount};
    if (push_ok) begin
      we = 1'b1;
    end else if (cmd.calc && (remain != '0)) begin
      we    = 1'b1;
      waddr = head_r;
      wdata = {rd_value, remain};
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    need_nxt   = need_r;
    taken_nxt  = taken_r;
    total_nxt  = total_r;
    prod_nxt   = prod_r;
    status_nxt = status_r;
    if (cmd.accept) begin
      need_nxt   = in_amount;
      taken_nxt  = '0;
      total_nxt  = '0;
      status_nxt = ((in_cmd == CMD_PUSH) && full) ? STATUS_DROP : STATUS_OK;
      if (push_ok) begin
        tail_nxt = ring_next(tail_r);
        occ_nxt  = occ_r + OW'(1);
      end
    end
    if (cmd.calc) begin
      prod_nxt  = TOTAL_W'(sub) * TOTAL_W'(rd_value);
      taken_nxt = taken_r + sub;
      need_nxt  = need_r - sub;
      if (remain == '0) begin
        head_nxt = ring_next(head_r);
        occ_nxt  = occ_r - OW'(1);
      end
    end
    if (cmd.acc) begin
      total_nxt = total_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r   <= need_nxt;
    taken_r  <= taken_nxt;
    total_r  <= total_nxt;
    prod_r   <= prod_nxt;
    status_r <= status_nxt;
    if (cmd.load_out) begin
      out_total_r  <= total_r;
      out_taken_r  <= taken_r;
      out_status_r <= status_r;
    end
  end

  assign sts.start_loop = (in_cmd == CMD_TAKE) && (in_amount != '0) && (occ_r != '0);
  assign sts.more       = (need_r != '0) && (occ_r != '0);

  assign out_total  = out_total_r;
  assign out_taken  = out_taken_r;
  assign out_status = out_status_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(QUEUE_DEPTH))
    else $error("occupancy above ring depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_r == '0) || full) |-> (head_r == tail_r))
    else $error("head and tail disagree with empty or full ring");

  a_need_down: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc |=> (need_r <= $past(need_r)) && (taken_r >= $past(taken_r)))
    else $error("take loop moved need or taken the wrong way");

  a_push_no_loop: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |-> !sts.start_loop)
    else $error("push started the take loop");

endmodule : rlf_dp
`default_nettype wire

### test/run_length_fifo_weighted_take_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_fifo_weighted_take_tb
// Self-checking bench for the run-length FIFO. A scoreboard keeps its own
// ring of runs and works out the total/taken/status word for every accepted
// command word; each result word is checked field by field against the oldest
// expected word. Directed words hit the corner cases first, then random
// phases with push/take bias, random gaps on the sender and random stalls on
// the receiver.
// ----------------------------------------------------------------------------
module run_length_fifo_weighted_take_tb;
  import rlf_pkg::*;

  localparam int DEPTH      = 16;
  localparam int RAND_WORDS = 1200;
  // worst case per word is a gap, a 16-run take and a stall;
  // the limit leaves a wide margin over that for every word
  localparam int CYCLE_LIMIT = 400000;
  // longest take walks the full ring of DEPTH runs
  localparam int DRAIN_CYCLES = 40;
  // room for result words still owed; only a few are ever in flight
  localparam int OWED_DEPTH = 16;

  // one result word as the block reports it
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] taken;
    logic               status;
  } rlf_result_t;

  // Scoreboard: mirrors the run ring and holds the result words still owed.
  class rlf_scoreboard;
    bit [VALUE_W-1:0] run_val [DEPTH];
    bit [COUNT_W-1:0] run_len [DEPTH];
    int unsigned      head, tail, fill;
    rlf_result_t      owed [OWED_DEPTH];
    int unsigned      owed_rd, owed_wr, owed_cnt;
    int unsigned      errors;

    function new();
      head     = 0;
      tail     = 0;
      fill     = 0;
      owed_rd  = 0;
      owed_wr  = 0;
      owed_cnt = 0;
      errors   = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return int'(owed_cnt);
    endfunction

    // Accepted command word: update the ring and queue the result it owes.
    task note_word(logic cmd, logic [VALUE_W-1:0] value,
                   logic [COUNT_W-1:0] amount);
      rlf_result_t      r;
      bit [COUNT_W-1:0] need, have, part;
      r = '0;
      if (cmd == CMD_PUSH) begin
        if (fill >= DEPTH) begin
          r.status = STATUS_DROP;
        end else begin
          run_val[tail] = value;
          run_len[tail] = amount;
          tail = (tail == DEPTH - 1) ? 0 : tail + 1;
          fill++;
        end
      end else begin
        need = amount;
        // zero-length runs at the head are popped for free
        while (fill > 0 && need > 0) begin
          have = run_len[head];
          part = (need < have) ? need : have;
          r.total += TOTAL_W'(part) * TOTAL_W'(run_val[head]);
          r.taken += part;
          need    -= part;
          have    -= part;
          if (have > 0) begin
            run_len[head] = have;
          end else begin
            head = (head == DEPTH - 1) ? 0 : head + 1;
            fill--;
          end
        end
      end
      if (owed_cnt == OWED_DEPTH) begin
        report("too many result words owed");
      end else begin
        owed[owed_wr] = r;
        owed_wr = (owed_wr == OWED_DEPTH - 1) ? 0 : owed_wr + 1;
        owed_cnt++;
      end
    endtask

    task check_result(logic [TOTAL_W-1:0] total, logic [COUNT_W-1:0] taken,
                      logic status);
      rlf_result_t e;
      if (owed_cnt == 0) begin
        report($sformatf("result word with nothing owed (total=%0h taken=%0d)",
                         total, taken));
      end else begin
        e = owed[owed_rd];
        owed_rd = (owed_rd == OWED_DEPTH - 1) ? 0 : owed_rd + 1;
        owed_cnt--;
        if (total !== e.total)
          report($sformatf("total %0h, expected %0h", total, e.total));
        if (taken !== e.taken)
          report($sformatf("taken %0d, expected %0d", taken, e.taken));
        if (status !== e.status)
          report($sformatf("status %0b, expected %0b", status, e.status));
      end
    endtask
  endclass

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                in_cmd       = CMD_PUSH;
  logic [VALUE_W-1:0]  in_run_value = '0;
  logic [COUNT_W-1:0]  in_amount    = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [TOTAL_W-1:0]  out_total;
  logic [COUNT_W-1:0]  out_taken;
  logic                out_status;

  // quiet flags switch off idling on one side for a whole phase
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int cycles   = 0;
  int stall_left = 0;

  rlf_scoreboard sb;

  run_length_fifo_weighted_take #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_run_value(in_run_value),
    .in_amount   (in_amount),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_total   (out_total),
    .out_taken   (out_taken),
    .out_status  (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: checks every accepted result word, then draws how many cycles
  // to hold out_stall. The count runs down whether or not a word is waiting,
  // so stalls land on every phase of the block's work.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_total, out_taken, out_status);
        stall_left = rx_quiet ? 0 : $urandom_range(0, 10);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0)
        stall_left--;
    end
  end

  // Sender: optional gap with valid low, then hold the word until accepted.
  // Valid is left high after acceptance so a back-to-back word never sees a
  // low/high pair of assignments in one step.
  task send_word(logic cmd, logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] amount);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_run_value <= value;
    in_amount    <= amount;
    do @(posedge clk); while (in_stall);
    sb.note_word(cmd, value, amount);
  endtask

  // mostly short runs so takes span several runs, plus zero and extremes
  function logic [COUNT_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom();
      2:       return '1;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function logic [COUNT_W-1:0] pick_want();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom();
      2:       return '1;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom();
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  initial begin
    int push_pct;
    sb = new();
    push_pct = 50;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed words ---
    // take from an empty ring, both zero and all-ones amount
    send_word(CMD_TAKE, '1, '1);
    send_word(CMD_TAKE, '0, '0);
    // largest run, a zero-length run, a zero-valued run
    send_word(CMD_PUSH, '1, '1);
    send_word(CMD_PUSH, 32'h1234_5678, '0);
    send_word(CMD_PUSH, '0, 32'd5);
    // fill the ring to the brim
    for (int k = 3; k < DEPTH; k++)
      send_word(CMD_PUSH, pick_value(), $urandom_range(1, 6));
    // push into a full ring is dropped
    send_word(CMD_PUSH, 32'hDEAD_BEEF, 32'd7);
    // zero take leaves the ring alone; partial take splits the head run
    send_word(CMD_TAKE, $urandom(), '0);
    send_word(CMD_TAKE, '0, 32'd3);
    // all-ones take stops inside the zero-valued run, max value times max-ish count
    send_word(CMD_TAKE, '0, '1);
    send_word(CMD_TAKE, '0, 32'd1);

    // --- random phases of 40 words, each with its own bias and idling ---
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      // hold off once until every owed result has come back
      if (n == RAND_WORDS / 2) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if ($urandom_range(1, 100) <= push_pct)
        send_word(CMD_PUSH, pick_value(), pick_len());
      else
        send_word(CMD_TAKE, $urandom(), pick_want());
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // let any stray word show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/rlf_pkg.sv
design/rlf_ram.sv
design/rlf_ctrl.sv
design/rlf_dp.sv
design/run_length_fifo_weighted_take.sv
test/run_length_fifo_weighted_take_tb.sv
